[rtl/lts_pkg.sv]
package lts_pkg;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_COMMENT = 4'd1,
        M_SLASH   = 4'd2,
        M_BANG    = 4'd3,
        M_EQUAL   = 4'd4,
        M_LESS    = 4'd5,
        M_GREATER = 4'd6,
        M_INT     = 4'd7,
        M_DOT     = 4'd8,
        M_FRAC    = 4'd9,
        M_IDENT   = 4'd10,
        M_STRING  = 4'd11
    } t_mode;

    localparam logic [5:0] K_LPAREN   = 6'd0;
    localparam logic [5:0] K_RPAREN   = 6'd1;
    localparam logic [5:0] K_LBRACE   = 6'd2;
    localparam logic [5:0] K_RBRACE   = 6'd3;
    localparam logic [5:0] K_COMMA    = 6'd4;
    localparam logic [5:0] K_DOT      = 6'd5;
    localparam logic [5:0] K_MINUS    = 6'd6;
    localparam logic [5:0] K_PLUS     = 6'd7;
    localparam logic [5:0] K_SEMI     = 6'd8;
    localparam logic [5:0] K_SLASH    = 6'd9;
    localparam logic [5:0] K_STAR     = 6'd10;
    localparam logic [5:0] K_BANG     = 6'd11;
    localparam logic [5:0] K_EQUAL    = 6'd13;
    localparam logic [5:0] K_GREATER  = 6'd15;
    localparam logic [5:0] K_LESS     = 6'd17;
    localparam logic [5:0] K_IDENT    = 6'd19;
    localparam logic [5:0] K_STRING   = 6'd20;
    localparam logic [5:0] K_NUMBER   = 6'd21;
    localparam logic [5:0] K_ERR_CHAR = 6'd38;
    localparam logic [5:0] K_ERR_STR  = 6'd39;
    localparam logic [5:0] K_EOF      = 6'd40;

    // keyword lookup on the first six bytes (byte 0 in bits 7:0)
    function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        case (len)
            3'd2: begin
                if (w[15:0] == "fi") k = 6'd28;
                if (w[15:0] == "ro") k = 6'd30;
            end
            3'd3: begin
                if (w[23:0] == "dna") k = 6'd22;
                if (w[23:0] == "rof") k = 6'd26;
                if (w[23:0] == "nuf") k = 6'd27;
                if (w[23:0] == "lin") k = 6'd29;
                if (w[23:0] == "rav") k = 6'd36;
            end
            3'd4: begin
                if (w[31:0] == "esle") k = 6'd24;
                if (w[31:0] == "siht") k = 6'd34;
                if (w[31:0] == "eurt") k = 6'd35;
            end
            3'd5: begin
                if (w[39:0] == "ssalc") k = 6'd23;
                if (w[39:0] == "eslaf") k = 6'd25;
                if (w[39:0] == "tnirp") k = 6'd31;
                if (w[39:0] == "repus") k = 6'd33;
                if (w[39:0] == "elihw") k = 6'd37;
            end
            3'd6: begin
                if (w[47:0] == "nruter") k = 6'd32;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

[rtl/lox_token_scanner_core.sv]
// channel | signals                                   | dir
// input   | i_valid, o_ready, i_ch                    | in
// output  | o_valid, i_ready, o_kind, o_start_offset,  | out
//         | o_token_length, o_line_number, o_last_of_run
//
// One byte is scanned per cycle: the byte updates the scanner state in the
// cycle it is accepted and its 0..3 tokens go into a three-entry output
// queue. A byte is taken whenever the queue has room for three tokens, so a
// steady one byte per cycle holds as long as the sink drains. Bytes that
// release two or three tokens stall the input while the queue drains one
// token per cycle. Reset is synchronous: line 1, offset 0, queue empty.
module lox_token_scanner_core #(
    parameter int OFFSET_BITS = 16,
    parameter int LINE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [15:0] o_line_number,
    output logic        o_last_of_run
);
    import lts_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OffMax = '1;
    localparam logic [LINE_BITS-1:0]   LineMax = '1;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_tok;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [47:0]            r_word, n_word;

    t_tok       r_q [3];
    logic [1:0] r_head;
    logic [1:0] r_cnt;

    t_tok       e_tok [3];
    logic [1:0] e_cnt;

    logic                   acc, pop, used;
    logic [7:0]             c;
    logic                   is_dig, is_alp;
    logic [OFFSET_BITS-1:0] pos_inc, sp_pos, sp_inc, sp_dot, dot_off;
    logic [5:0]             base;

    assign acc = i_valid && o_ready;
    assign pop = o_valid && i_ready;
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid = (r_cnt != 2'd0);
    assign o_kind = r_q[r_head].kind;
    assign o_start_offset = r_q[r_head].start;
    assign o_token_length = r_q[r_head].len;
    assign o_line_number = r_q[r_head].line;
    assign o_last_of_run = r_q[r_head].last;

    assign c = i_ch;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign pos_inc = (r_pos == OffMax) ? OffMax : r_pos + 1'b1;
    assign dot_off = r_pos - 1'b1;

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] e,
                                                    input logic [OFFSET_BITS-1:0] b);
        return (e >= b) ? e - b : '0;
    endfunction

    assign sp_pos = span(r_pos, r_begin);
    assign sp_inc = span(pos_inc, r_begin);
    assign sp_dot = span(dot_off, r_begin);

    function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        return x[15:0];
    endfunction

    always_comb begin
        t_tok t;
        logic [15:0] l16;
        logic [31:0] lx;
        n_mode = r_mode;
        n_pos = r_pos;
        n_begin = r_begin;
        n_line = r_line;
        n_word = r_word;
        e_cnt = 2'd0;
        used = 1'b0;
        t = '0;
        for (int i = 0; i < 3; i++) e_tok[i] = '0;
        base = K_BANG;
        case (r_mode)
            M_BANG:  base = K_BANG;
            M_EQUAL: base = K_EQUAL;
            M_GREATER: base = K_GREATER;
            default: base = K_LESS;
        endcase
        // line is sampled at emit time from r_line; a newline byte only changes it
        // for later bytes, so a token emitted on that byte keeps the old line
        lx = 32'(r_line);
        l16 = lx[15:0];
        t.line = l16;
        case (r_mode)
            M_COMMENT: begin
                if (c == "\n" || c == 8'd0) n_mode = M_IDLE;
                else used = 1'b1;
            end
            M_SLASH: begin
                if (c == "/") begin
                    n_mode = M_COMMENT; used = 1'b1;
                end else begin
                    t.kind = K_SLASH; t.start = off16(r_begin); t.len = off16(sp_pos);
                    e_tok[0] = t; e_cnt = 2'd1; n_mode = M_IDLE;
                end
            end
            M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                n_mode = M_IDLE;
                t.start = off16(r_begin);
                if (c == "=") begin
                    t.kind = base + 6'd1; t.len = off16(sp_inc); used = 1'b1;
                end else begin
                    t.kind = base; t.len = off16(sp_pos);
                end
                e_tok[0] = t; e_cnt = 2'd1;
            end
            M_INT, M_FRAC: begin
                if (is_dig) used = 1'b1;
                else if (c == "." && r_mode == M_INT) begin
                    n_mode = M_DOT; used = 1'b1;
                end else begin
                    t.kind = K_NUMBER; t.start = off16(r_begin); t.len = off16(sp_pos);
                    e_tok[0] = t; e_cnt = 2'd1; n_mode = M_IDLE;
                end
            end
            M_DOT: begin
                if (is_dig) begin
                    n_mode = M_FRAC; used = 1'b1;
                end else begin
                    t.kind = K_NUMBER; t.start = off16(r_begin); t.len = off16(sp_dot);
                    e_tok[0] = t;
                    t.kind = K_DOT; t.start = off16(dot_off); t.len = 16'd1;
                    e_tok[1] = t; e_cnt = 2'd2; n_mode = M_IDLE;
                end
            end
            M_IDENT: begin
                if (is_alp || is_dig) begin
                    used = 1'b1;
                    for (int j = 0; j < 6; j++)
                        if (sp_pos == OFFSET_BITS'(j)) n_word[8*j +: 8] = r_word[8*j +: 8] | c;
                end else begin
                    t.kind = (sp_pos > OFFSET_BITS'(6)) ? K_IDENT
                           : word_kind(r_word, sp_pos[2:0]);
                    t.start = off16(r_begin); t.len = off16(sp_pos);
                    e_tok[0] = t; e_cnt = 2'd1; n_mode = M_IDLE;
                end
            end
            M_STRING: begin
                if (c == "\"") begin
                    t.kind = K_STRING; t.start = off16(r_begin); t.len = off16(sp_inc);
                    e_tok[0] = t; e_cnt = 2'd1; n_mode = M_IDLE; used = 1'b1;
                end else if (c == 8'd0) begin
                    t.kind = K_ERR_STR; t.start = off16(r_begin); t.len = 16'd0;
                    e_tok[0] = t; e_cnt = 2'd1; n_mode = M_IDLE;
                end else begin
                    used = 1'b1;
                    if (c == "\n" && r_line != LineMax) n_line = r_line + 1'b1;
                end
            end
            default: n_mode = M_IDLE;
        endcase

        if (!used) begin
            t = '0;
            t.line = l16;
            t.start = off16(r_pos);
            t.len = 16'd1;
            if (c == 8'd0) begin
                t.kind = K_EOF; t.len = 16'd0;
                e_tok[e_cnt] = t; e_cnt = e_cnt + 2'd1;
            end else begin
                n_begin = r_pos;
                case (c)
                    " ", "\r", "\t": ;
                    "\n": if (r_line != LineMax) n_line = r_line + 1'b1;
                    "/": n_mode = M_SLASH;
                    "!": n_mode = M_BANG;
                    "=": n_mode = M_EQUAL;
                    "<": n_mode = M_LESS;
                    ">": n_mode = M_GREATER;
                    "\"": n_mode = M_STRING;
                    default: begin
                        if (is_dig) n_mode = M_INT;
                        else if (is_alp) begin
                            n_mode = M_IDENT; n_word = {40'd0, c};
                        end else begin
                            case (c)
                                "(": t.kind = K_LPAREN;
                                ")": t.kind = K_RPAREN;
                                "{": t.kind = K_LBRACE;
                                "}": t.kind = K_RBRACE;
                                ",": t.kind = K_COMMA;
                                ".": t.kind = K_DOT;
                                "-": t.kind = K_MINUS;
                                "+": t.kind = K_PLUS;
                                ";": t.kind = K_SEMI;
                                "*": t.kind = K_STAR;
                                default: begin
                                    t.kind = K_ERR_CHAR; t.len = 16'd0;
                                end
                            endcase
                            e_tok[e_cnt] = t; e_cnt = e_cnt + 2'd1;
                        end
                    end
                endcase
            end
        end
        if (e_cnt != 2'd0) e_tok[e_cnt - 2'd1].last = 1'b1;

        if (c == 8'd0) begin
            n_mode = M_IDLE; n_pos = '0; n_begin = '0;
            n_line = LINE_BITS'(1); n_word = '0;
        end else begin
            n_pos = pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos <= '0;
            r_begin <= '0;
            r_line <= LINE_BITS'(1);
            r_word <= '0;
            r_head <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_mode <= n_mode;
                r_pos <= n_pos;
                r_begin <= n_begin;
                r_line <= n_line;
                r_word <= n_word;
            end
            // queue is empty (or emptying) whenever a byte is accepted
            if (acc) begin
                r_head <= 2'd0;
                r_cnt <= e_cnt;
            end else if (pop) begin
                r_head <= r_head + 2'd1;
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 0; i < 3; i++) r_q[i] <= e_tok[i];
        end
    end

endmodule
